// File: hdl/gnd_pkg.sv
// Shared types and constants for the greedy note dispenser.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package gnd_pkg;

  localparam int MaxDenoms = 16;
  localparam int IdxW      = $clog2(MaxDenoms);
  localparam int CntW      = $clog2(MaxDenoms + 1);
  localparam int ValW      = 31;
  localparam int TagW      = 8;
  localparam int StepW     = $clog2(ValW + 1);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PAY   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entry_t          wentry;
    logic            re;
    logic [IdxW-1:0] raddr;
  } tbl_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hdl/greedy_note_dispenser.sv
// Greedy note dispenser top level: sequencer, sorted table, shared divider.
// Depends on gnd_pkg, gnd_table and gnd_div.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o   | op, denom_value, denom_tag, amount
//   out     | output    | out_valid_o / out_stall_i | is_summary, note_value, note_tag,
//           |           |                           | note_count, total_notes, remaining, last
//
// Clear and an unused op complete on acceptance. A load is accepted, then compares against
// table entries from the tail, shifting smaller ones down, and writes the new entry in place.
// A pay reads the table entries in order, waits on the one-bit-per-cycle divider for each, and
// emits one transaction per nonzero quotient, stopping early once the amount reaches zero.
// Reset empties the table; entries are never read beyond the fill count.
// in_stall_o stays high until the last result is in the output register; a stalled output holds.
`default_nettype none

module greedy_note_dispenser (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output wire logic                     in_stall_o,
  input  wire logic [1:0]               op_i,
  input  wire logic [gnd_pkg::ValW-1:0] denom_value_i,
  input  wire logic [gnd_pkg::TagW-1:0] denom_tag_i,
  input  wire logic [gnd_pkg::ValW-1:0] amount_i,
  output wire logic                     out_valid_o,
  input  wire logic                     out_stall_i,
  output wire logic                     is_summary_o,
  output wire logic [gnd_pkg::ValW-1:0] note_value_o,
  output wire logic [gnd_pkg::TagW-1:0] note_tag_o,
  output wire logic [gnd_pkg::ValW-1:0] note_count_o,
  output wire logic [gnd_pkg::ValW-1:0] total_notes_o,
  output wire logic [gnd_pkg::ValW-1:0] remaining_o,
  output wire logic                     last_o
);

  localparam int ValW = gnd_pkg::ValW;
  localparam int TagW = gnd_pkg::TagW;
  localparam int IdxW = gnd_pkg::IdxW;
  localparam int CntW = gnd_pkg::CntW;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LD_RD    = 8'b0000_0010,
    S_LD_CMP   = 8'b0000_0100,
    S_PAY_RD   = 8'b0000_1000,
    S_PAY_DIV  = 8'b0001_0000,
    S_PAY_WAIT = 8'b0010_0000,
    S_EMIT     = 8'b0100_0000,
    S_SUM      = 8'b1000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [ValW-1:0]     new_val_q, new_val_d;
  logic [TagW-1:0]     new_tag_q, new_tag_d;
  logic [ValW-1:0]     amt_q, amt_d;
  logic [ValW-1:0]     total_q, total_d;
  logic [ValW-1:0]     cnt_q, cnt_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic                out_summary;
  logic                summ_q;
  logic [ValW-1:0]     oval_q;
  logic [TagW-1:0]     otag_q;
  logic [ValW-1:0]     ocnt_q;
  logic [ValW-1:0]     otot_q;
  logic [ValW-1:0]     orem_q;

  gnd_pkg::tbl_req_t   tbl_req;
  gnd_pkg::entry_t     rdata;
  gnd_pkg::div_stat_t  div_stat;
  logic                div_start;
  logic [ValW-1:0]     div_quot;
  logic [ValW-1:0]     div_rem;
  logic                in_acc;
  logic                slot_free;

  gnd_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (rdata)
  );

  gnd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (amt_q),
    .divisor_i  (rdata.value),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign in_acc    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    idx_d          = idx_q;
    pos_d          = pos_q;
    new_val_d      = new_val_q;
    new_tag_d      = new_tag_q;
    amt_d          = amt_q;
    total_d        = total_q;
    cnt_d          = cnt_q;
    tbl_req        = '0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    out_summary    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (gnd_pkg::op_e'(op_i))
            gnd_pkg::OP_CLEAR: count_d = '0;
            gnd_pkg::OP_LOAD: begin
              // drop zero values and loads into a full table
              if (denom_value_i != '0 && count_q < CntW'(gnd_pkg::MaxDenoms)) begin
                new_val_d = denom_value_i;
                new_tag_d = denom_tag_i;
                pos_d     = count_q[IdxW-1:0];
                state_d   = S_LD_RD;
              end
            end
            gnd_pkg::OP_PAY: begin
              amt_d   = amount_i;
              total_d = '0;
              idx_d   = '0;
              state_d = S_PAY_RD;
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        if (pos_q == '0) begin
          tbl_req.we     = 1'b1;
          tbl_req.waddr  = pos_q;
          tbl_req.wentry = '{value: new_val_q, tag: new_tag_q};
          count_d        = count_q + 1'b1;
          state_d        = S_IDLE;
        end else begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = pos_q - 1'b1;
          state_d       = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = pos_q;
        if (rdata.value < new_val_q) begin
          // shift the smaller entry down one place and keep searching
          tbl_req.wentry = rdata;
          pos_d          = pos_q - 1'b1;
          state_d        = S_LD_RD;
        end else begin
          tbl_req.wentry = '{value: new_val_q, tag: new_tag_q};
          count_d        = count_q + 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_PAY_RD: begin
        if (idx_q == count_q || amt_q == '0) begin
          state_d = S_SUM;
        end else begin
          tbl_req.re    = 1'b1;
          tbl_req.raddr = idx_q[IdxW-1:0];
          state_d       = S_PAY_DIV;
        end
      end
      S_PAY_DIV: begin
        div_start = 1'b1;
        state_d   = S_PAY_WAIT;
      end
      S_PAY_WAIT: begin
        if (div_stat.done) begin
          amt_d   = div_rem;
          total_d = total_q + div_quot;
          cnt_d   = div_quot;
          if (div_quot != '0) begin
            state_d = S_EMIT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_PAY_RD;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + 1'b1;
          state_d  = S_PAY_RD;
        end
      end
      S_SUM: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_summary = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    pos_q     <= pos_d;
    new_val_q <= new_val_d;
    new_tag_q <= new_tag_d;
    amt_q     <= amt_d;
    total_q   <= total_d;
    cnt_q     <= cnt_d;
    if (out_load) begin
      summ_q <= out_summary;
      oval_q <= out_summary ? '0 : rdata.value;
      otag_q <= out_summary ? '0 : rdata.tag;
      ocnt_q <= out_summary ? '0 : cnt_q;
      otot_q <= out_summary ? total_q : '0;
      orem_q <= out_summary ? amt_q : '0;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign is_summary_o  = summ_q;
  assign note_value_o  = oval_q;
  assign note_tag_o    = otag_q;
  assign note_count_o  = ocnt_q;
  assign total_notes_o = otot_q;
  assign remaining_o   = orem_q;
  assign last_o        = summ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(gnd_pkg::MaxDenoms))
    else $error("table fill count above capacity");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_note_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_summary_o |-> note_count_o != '0 && note_value_o != '0)
    else $error("note transaction with zero count or value");

  a_load_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LD_CMP) && !(rdata.value < new_val_q) |=> count_q == $past(count_q) + 1'b1)
    else $error("load did not grow the table");

endmodule

`default_nettype wire

// File: hdl/gnd_table.sv
// Denomination table: one write port, one registered read port.
// Depends on gnd_pkg.
`default_nettype none

module gnd_table (
  input  wire                logic clk_i,
  input  var  gnd_pkg::tbl_req_t req_i,
  output var  gnd_pkg::entry_t   rdata_o
);

  gnd_pkg::entry_t mem [gnd_pkg::MaxDenoms];
  gnd_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wentry;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/gnd_div.sv
// Restoring divider, one quotient bit per cycle, for the pay walk.
// Depends on gnd_pkg.
`default_nettype none

module gnd_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [gnd_pkg::ValW-1:0] dividend_i,
  input  wire logic [gnd_pkg::ValW-1:0] divisor_i,
  output var  gnd_pkg::div_stat_t       stat_o,
  output wire logic [gnd_pkg::ValW-1:0] quot_o,
  output wire logic [gnd_pkg::ValW-1:0] rem_o
);

  localparam int W = gnd_pkg::ValW;

  logic [gnd_pkg::StepW-1:0] step_q, step_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [W-1:0]              rem_q, rem_d;
  logic [W-1:0]              quo_q, quo_d;
  logic [W-1:0]              dvs_q, dvs_d;
  logic [W:0]                trial;
  logic [W:0]                diff;

  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      step_d = gnd_pkg::StepW'(W);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // keep the difference only when it did not borrow
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == gnd_pkg::StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

// File: tb/tb_greedy_note_dispenser.sv
// Testbench for greedy_note_dispenser: a directed table and random clear/load/pay runs.
// Results are checked against the typed row or a predictor of sorted table and greedy walk.
// Depends on gnd_pkg and the greedy_note_dispenser RTL.
module tb_greedy_note_dispenser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ValW      = gnd_pkg::ValW;
  localparam int TagW      = gnd_pkg::TagW;
  localparam int MaxDenoms = gnd_pkg::MaxDenoms;

  typedef struct packed {
    logic            is_summary;
    logic [ValW-1:0] value;
    logic [TagW-1:0] tag;
    logic [ValW-1:0] count;
    logic [ValW-1:0] total;
    logic [ValW-1:0] remaining;
    logic            last;
  } note_t;

  typedef struct packed {
    gnd_pkg::op_e    op;
    logic [ValW-1:0] value;
    logic [TagW-1:0] tag;
    logic [ValW-1:0] amount;
    logic [4:0]      rep;
    logic            typed;
    logic [ValW-1:0] total;
    logic [ValW-1:0] remaining;
  } dir_row_t;

  localparam logic [ValW-1:0] ValMax    = {ValW{1'b1}};
  localparam int              RandItems = 425;

  logic            clk_i;
  logic            rst_n;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      op_q;
  logic [ValW-1:0] denom_value_q;
  logic [TagW-1:0] denom_tag_q;
  logic [ValW-1:0] amount_q;
  logic            out_valid;
  logic            out_stall;
  logic            is_summary;
  logic [ValW-1:0] note_value;
  logic [TagW-1:0] note_tag;
  logic [ValW-1:0] note_count;
  logic [ValW-1:0] total_notes;
  logic [ValW-1:0] remaining;
  logic            last;

  // Predictor copy of the denomination table
  logic [ValW-1:0] bank_value [MaxDenoms];
  logic [TagW-1:0] bank_tag   [MaxDenoms];
  int              bank_fill;

  note_t    due_notes[$];
  dir_row_t dir_rows[$];
  int       sent;
  int       mismatches;

  greedy_note_dispenser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op_q),
    .denom_value_i (denom_value_q),
    .denom_tag_i   (denom_tag_q),
    .amount_i      (amount_q),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .is_summary_o  (is_summary),
    .note_value_o  (note_value),
    .note_tag_o    (note_tag),
    .note_count_o  (note_count),
    .total_notes_o (total_notes),
    .remaining_o   (remaining),
    .last_o        (last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void predict_dispense(gnd_pkg::op_e op, logic [ValW-1:0] value,
                                           logic [TagW-1:0] tag, logic [ValW-1:0] amount);
    int              pos;
    logic [ValW-1:0] rem;
    logic [ValW-1:0] total;
    logic [ValW-1:0] cnt;
    note_t           n;
    unique case (op)
      gnd_pkg::OP_CLEAR: bank_fill = 0;
      gnd_pkg::OP_LOAD: begin
        if (value != '0 && bank_fill < MaxDenoms) begin
          // insert after every entry of greater or equal value
          pos = bank_fill;
          while (pos > 0 && bank_value[pos-1] < value) pos--;
          for (int i = bank_fill; i > pos; i--) begin
            bank_value[i] = bank_value[i-1];
            bank_tag[i]   = bank_tag[i-1];
          end
          bank_value[pos] = value;
          bank_tag[pos]   = tag;
          bank_fill++;
        end
      end
      gnd_pkg::OP_PAY: begin
        rem   = amount;
        total = '0;
        for (int i = 0; i < bank_fill && rem != '0; i++) begin
          cnt   = rem / bank_value[i];
          rem   = rem - cnt * bank_value[i];
          total = total + cnt;
          if (cnt != '0) begin
            n       = '0;
            n.value = bank_value[i];
            n.tag   = bank_tag[i];
            n.count = cnt;
            due_notes.push_back(n);
          end
        end
        n            = '0;
        n.is_summary = 1'b1;
        n.total      = total;
        n.remaining  = rem;
        n.last       = 1'b1;
        due_notes.push_back(n);
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(gnd_pkg::op_e op, logic [ValW-1:0] value,
                                  logic [TagW-1:0] tag,
                                  logic [ValW-1:0] amount, logic [4:0] rep = 5'd1,
                                  logic typed = 1'b0, logic [ValW-1:0] total = '0,
                                  logic [ValW-1:0] rem = '0);
    dir_row_t r;
    r.op        = op;
    r.value     = value;
    r.tag       = tag;
    r.amount    = amount;
    r.rep       = rep;
    r.typed     = typed;
    r.total     = total;
    r.remaining = rem;
    dir_rows.push_back(r);
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(gnd_pkg::op_e op, logic [ValW-1:0] value, logic [TagW-1:0] tag,
                           logic [ValW-1:0] amount, logic typed = 1'b0,
                           logic [ValW-1:0] typed_total = '0,
                           logic [ValW-1:0] typed_rem = '0);
    int    gap;
    note_t n;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    op_q          <= op;
    denom_value_q <= value;
    denom_tag_q   <= tag;
    amount_q      <= amount;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (typed) begin
      n            = '0;
      n.is_summary = 1'b1;
      n.total      = typed_total;
      n.remaining  = typed_rem;
      n.last       = 1'b1;
      due_notes.push_back(n);
    end else begin
      predict_dispense(op, value, tag, amount);
    end
    if (op != gnd_pkg::OP_NONE) sent++;
  endtask

  // Receiver: random stall per transaction, two long hold-offs to back up the input
  initial begin
    int n;
    int rx_count;
    out_stall <= 1'b0;
    rx_count = 0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      n = (rx_count == 25 || rx_count == 180) ? 400 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      rx_count++;
    end
  end

  always @(posedge clk_i) begin : result_check
    note_t got;
    note_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.is_summary = is_summary;
      got.value      = note_value;
      got.tag        = note_tag;
      got.count      = note_count;
      got.total      = total_notes;
      got.remaining  = remaining;
      got.last       = last;
      if (due_notes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sum=%0d val=%0h tag=%0h cnt=%0h tot=%0h rem=%0h last=%0d",
                   got.is_summary, got.value, got.tag, got.count, got.total,
                   got.remaining, got.last);
      end else begin
        want = due_notes.pop_front();
        if (got.is_summary !== want.is_summary || got.value !== want.value ||
            got.tag !== want.tag || got.count !== want.count ||
            got.total !== want.total || got.remaining !== want.remaining ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: sum=%0d val=%0h tag=%0h cnt=%0h tot=%0h rem=%0h last=%0d",
                     want.is_summary, want.value, want.tag, want.count, want.total,
                     want.remaining, want.last);
            $display("         got: sum=%0d val=%0h tag=%0h cnt=%0h tot=%0h rem=%0h last=%0d",
                     got.is_summary, got.value, got.tag, got.count, got.total,
                     got.remaining, got.last);
          end
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("** greedy_note_dispenser: FAILED **");
    $finish;
  end

  initial begin
    dir_row_t        row;
    logic [ValW-1:0] v;
    logic [ValW-1:0] a;
    logic [ValW-1:0] top;
    int              rand_goal;
    in_valid      <= 1'b0;
    op_q          <= gnd_pkg::OP_NONE;
    denom_value_q <= '0;
    denom_tag_q   <= '0;
    amount_q      <= '0;
    rst_n         <= 1'b0;
    sent       = 0;
    mismatches = 0;
    bank_fill  = 0;

    // Pays on an empty table, zero values and amounts, the full-range extremes,
    // equal values in load order, a load into a full table, and the unused op
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd12345, 5'd1, 1'b1, '0, 31'd12345);
    add_row(gnd_pkg::OP_PAY, ValMax, 8'hFF, '0, 5'd1, 1'b1, '0, '0);
    add_row(gnd_pkg::OP_LOAD, '0, 8'd5, '0);
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd100, 5'd1, 1'b1, '0, 31'd100);
    add_row(gnd_pkg::OP_NONE, 31'h2AAA_AAAA, 8'h5A, 31'h5555_5555);
    add_row(gnd_pkg::OP_LOAD, ValMax, 8'hFF, '0);
    add_row(gnd_pkg::OP_PAY, '0, '0, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, ValMax - 31'd1, 5'd1, 1'b1, '0, ValMax - 31'd1);
    add_row(gnd_pkg::OP_LOAD, 31'd1, 8'h00, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, '0, 5'd1, 1'b1, '0, '0);
    add_row(gnd_pkg::OP_CLEAR, ValMax, 8'hFF, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd50, 5'd1, 1'b1, '0, 31'd50);
    add_row(gnd_pkg::OP_LOAD, 31'd100, 8'd1, '0);
    add_row(gnd_pkg::OP_LOAD, 31'd50, 8'd2, '0);
    add_row(gnd_pkg::OP_LOAD, 31'd100, 8'd3, '0);
    add_row(gnd_pkg::OP_LOAD, 31'd20, 8'd4, '0);
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd370);
    add_row(gnd_pkg::OP_LOAD, 31'd3, 8'd10, '0, 5'd12);
    add_row(gnd_pkg::OP_LOAD, 31'd7, 8'd99, '0);
    add_row(gnd_pkg::OP_PAY, '0, '0, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd9);
    add_row(gnd_pkg::OP_CLEAR, '0, '0, '0);
    add_row(gnd_pkg::OP_NONE, ValMax, 8'hFF, ValMax);
    add_row(gnd_pkg::OP_PAY, '0, '0, 31'd1, 5'd1, 1'b1, '0, 31'd1);

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int k = 0; k < row.rep; k++)
        send_item(row.op, row.value + ValW'(k), row.tag + TagW'(k), row.amount,
                  row.typed, row.total, row.remaining);
    end

    // Mostly well-formed runs: clear, load the table, then several pays; the rest is noise
    rand_goal = sent + RandItems;
    while (sent < rand_goal) begin
      if ($urandom_range(0, 4) != 0) begin
        send_item(gnd_pkg::OP_CLEAR, ValW'($urandom), TagW'($urandom), ValW'($urandom));
        repeat ($urandom_range(1, 18)) begin
          case ($urandom_range(0, 11))
            0, 1:    v = ValW'($urandom_range(1, 10));
            2, 3:    v = ValW'($urandom_range(1, 200));
            4, 5:    v = ValW'($urandom_range(1, 100000));
            6, 7:    v = ValW'($urandom_range(1, 32'h7FFF_FFFF));
            8, 9:    v = (bank_fill != 0) ? bank_value[$urandom_range(0, bank_fill - 1)]
                                          : 31'd1;
            10:      v = ValW'($urandom_range(1, 32'd1 << $urandom_range(0, 30)));
            default: v = '0;
          endcase
          send_item(gnd_pkg::OP_LOAD, v, TagW'($urandom), ValW'($urandom));
        end
        repeat ($urandom_range(2, 6)) begin
          top = (bank_fill != 0) ? bank_value[0] : 31'd1000;
          case ($urandom_range(0, 9))
            0:       a = '0;
            1, 2:    a = ValW'($urandom);
            3:       a = ValW'($urandom_range(0, 31));
            default: a = (top > 31'h2000_0000) ? ValW'($urandom)
                                               : ValW'($urandom_range(0, 3 * top + 7));
          endcase
          send_item(gnd_pkg::OP_PAY, ValW'($urandom), TagW'($urandom), a);
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(gnd_pkg::op_e'($urandom_range(0, 3)), ValW'($urandom), TagW'($urandom),
                    ValW'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (due_notes.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);

    if (mismatches == 0 && due_notes.size() == 0) begin
      $display("** greedy_note_dispenser: PASSED **");
    end else begin
      $display("** greedy_note_dispenser: FAILED **");
    end
    $finish;
  end

endmodule

// File: greedy_note_dispenser.f
hdl/gnd_pkg.sv
hdl/gnd_table.sv
hdl/gnd_div.sv
hdl/greedy_note_dispenser.sv
tb/tb_greedy_note_dispenser.sv
